/* src/rmq_pkg.sv */
// shared constants, types and branch codes for the rotation matrix to quaternion block
// no dependencies
package rmq_pkg;

    localparam int FRAC_BITS = 14;
    localparam int IN_W      = 16;
    localparam int ONE       = 1 << FRAC_BITS;

    // radicand magnitude: one plus three diagonal elements
    localparam int RAD_W  = ((FRAC_BITS > IN_W - 1) ? FRAC_BITS : IN_W - 1) + 3;
    localparam int SQ_RAW = RAD_W + FRAC_BITS;
    localparam int SQ_W   = SQ_RAW + (SQ_RAW % 2);
    localparam int ROOT_W = SQ_W / 2;
    localparam int T_W    = ROOT_W + 1;
    localparam int REM_W  = ROOT_W + 3;

    // off-diagonal numerators and the divider
    localparam int NUM_W = IN_W + 1;
    localparam int Q_W   = IN_W - 1;
    localparam int DIV_W = NUM_W + FRAC_BITS + 1;
    localparam int CMP_W = (DIV_W > T_W + 1 + Q_W) ? DIV_W : T_W + 1 + Q_W;

    localparam logic signed [IN_W-1:0] SAT_MAX = {1'b0, {(IN_W-1){1'b1}}};
    localparam logic signed [IN_W-1:0] SAT_MIN = {1'b1, {(IN_W-1){1'b0}}};

    typedef enum logic [1:0] {
        COMP_X = 2'd0,
        COMP_Y = 2'd1,
        COMP_Z = 2'd2,
        COMP_W = 2'd3
    } comp_t;

    typedef struct packed {
        logic [3:0][NUM_W-1:0] mag;
        logic [3:0]            neg;
        comp_t                 big;
        logic                  degen;
    } side_t;

endpackage

/* src/rmq_front.sv */
// branch choice, radicand and numerators, one register stage
// depends on rmq_pkg
module rmq_front import rmq_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   valid_in,
    input  logic signed [IN_W-1:0] r00, r01, r02,
    input  logic signed [IN_W-1:0] r10, r11, r12,
    input  logic signed [IN_W-1:0] r20, r21, r22,
    output logic                   valid_out,
    output logic [RAD_W-1:0]       rad_out,
    output side_t                  side_out
);

    logic signed [RAD_W:0]  e00, e11, e22, tr, rad;
    logic signed [NUM_W-1:0] n [4];
    logic signed [NUM_W-1:0] d21_12, d02_20, d10_01, s01_10, s02_20, s12_21;
    side_t                  side_next;
    logic                   valid_reg;
    logic [RAD_W-1:0]       rad_reg;
    side_t                  side_reg;

    always_comb begin
        e00 = (RAD_W+1)'(r00);
        e11 = (RAD_W+1)'(r11);
        e22 = (RAD_W+1)'(r22);
        tr  = e00 + e11 + e22;
        d21_12 = NUM_W'(r21) - NUM_W'(r12);
        d02_20 = NUM_W'(r02) - NUM_W'(r20);
        d10_01 = NUM_W'(r10) - NUM_W'(r01);
        s01_10 = NUM_W'(r01) + NUM_W'(r10);
        s02_20 = NUM_W'(r02) + NUM_W'(r20);
        s12_21 = NUM_W'(r12) + NUM_W'(r21);
        side_next.big = COMP_W;
        if (tr > 0) begin
            rad = tr + (RAD_W+1)'(ONE);
            side_next.big = COMP_W;
            n[COMP_X] = d21_12; n[COMP_Y] = d02_20; n[COMP_Z] = d10_01; n[COMP_W] = '0;
        end else if (r00 > r11 && r00 > r22) begin
            rad = (RAD_W+1)'(ONE) + e00 - e11 - e22;
            side_next.big = COMP_X;
            n[COMP_W] = d21_12; n[COMP_Y] = s01_10; n[COMP_Z] = s02_20; n[COMP_X] = '0;
        end else if (r11 > r22) begin
            rad = (RAD_W+1)'(ONE) + e11 - e00 - e22;
            side_next.big = COMP_Y;
            n[COMP_W] = d02_20; n[COMP_X] = s01_10; n[COMP_Z] = s12_21; n[COMP_Y] = '0;
        end else begin
            rad = (RAD_W+1)'(ONE) + e22 - e00 - e11;
            side_next.big = COMP_Z;
            n[COMP_W] = d10_01; n[COMP_X] = s02_20; n[COMP_Y] = s12_21; n[COMP_Z] = '0;
        end
        side_next.degen = (rad <= 0);
        for (int i = 0; i < 4; i++) begin
            side_next.neg[i] = n[i][NUM_W-1];
            side_next.mag[i] = n[i][NUM_W-1] ? NUM_W'(-n[i]) : NUM_W'(n[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg  <= side_next.degen ? RAD_W'(1) : rad[RAD_W-1:0];
            side_reg <= side_next;
        end
    end

    assign valid_out = valid_reg;
    assign rad_out   = rad_reg;
    assign side_out  = side_reg;

endmodule

/* src/rmq_sqrt.sv */
// pipelined rounded square root, one root bit per stage plus a rounding stage
// depends on rmq_pkg
module rmq_sqrt import rmq_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             valid_in,
    input  logic [RAD_W-1:0] rad_in,
    input  side_t            side_in,
    output logic             valid_out,
    output logic [T_W-1:0]   t_out,
    output side_t            side_out
);

    logic [SQ_W-1:0]   v_reg    [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    side_t             side_reg [ROOT_W];
    logic              vld_reg  [ROOT_W];
    logic [T_W-1:0]    t_reg;
    side_t             tside_reg;
    logic              tvld_reg;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [SQ_W-1:0]   v_cur;
        logic [REM_W-1:0]  rem_cur, rem_sh, trial;
        logic [ROOT_W-1:0] root_cur;
        side_t             side_cur;
        logic              vld_cur;

        if (k == 0) begin : g_first
            assign v_cur    = SQ_W'(rad_in) << FRAC_BITS;
            assign rem_cur  = '0;
            assign root_cur = '0;
            assign side_cur = side_in;
            assign vld_cur  = valid_in;
        end else begin : g_next
            assign v_cur    = v_reg[k-1];
            assign rem_cur  = rem_reg[k-1];
            assign root_cur = root_reg[k-1];
            assign side_cur = side_reg[k-1];
            assign vld_cur  = vld_reg[k-1];
        end

        assign rem_sh = {rem_cur[REM_W-3:0], v_cur[SQ_W-1 -: 2]};
        assign trial  = {1'b0, root_cur, 2'b01};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                v_reg[k]    <= v_cur << 2;
                side_reg[k] <= side_cur;
                if (rem_sh >= trial) begin
                    rem_reg[k]  <= rem_sh - trial;
                    root_reg[k] <= {root_cur[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg[k]  <= rem_sh;
                    root_reg[k] <= {root_cur[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    // round to nearest: remainder above the root means past the half point
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tvld_reg <= 1'b0;
        end else if (en) begin
            tvld_reg <= vld_reg[ROOT_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tside_reg <= side_reg[ROOT_W-1];
            if (rem_reg[ROOT_W-1] > REM_W'(root_reg[ROOT_W-1])) begin
                t_reg <= T_W'(root_reg[ROOT_W-1]) + T_W'(1);
            end else begin
                t_reg <= T_W'(root_reg[ROOT_W-1]);
            end
        end
    end

    assign valid_out = tvld_reg;
    assign t_out     = t_reg;
    assign side_out  = tside_reg;

endmodule

/* src/rmq_div.sv */
// four-lane pipelined restoring divider, n * one / (2t) rounded, one quotient bit per stage
// depends on rmq_pkg
module rmq_div import rmq_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 valid_in,
    input  logic [T_W-1:0]       t_in,
    input  side_t                side_in,
    output logic                 valid_out,
    output logic [3:0][Q_W-1:0]  q_out,
    output logic [3:0]           ovf_out,
    output logic [T_W-1:0]       t_out,
    output side_t                side_out
);

    // setup stage: dividend, divisor and overflow check
    logic [3:0][DIV_W-1:0] rem0_reg;
    logic [3:0]            ovf0_reg;
    logic [T_W:0]          d0_reg;
    logic [T_W-1:0]        t0_reg;
    side_t                 side0_reg;
    logic                  vld0_reg;

    logic [3:0][DIV_W-1:0] rem_reg [Q_W];
    logic [3:0][Q_W-1:0]   q_reg   [Q_W];
    logic [3:0]            ovf_reg [Q_W];
    logic [T_W:0]          d_reg   [Q_W];
    logic [T_W-1:0]        t_reg   [Q_W];
    side_t                 side_reg[Q_W];
    logic                  vld_reg [Q_W];

    logic [3:0][DIV_W-1:0] dvd;
    logic [3:0]            ovf_next;
    logic [T_W:0]          dsr;

    always_comb begin
        dsr = {t_in, 1'b0};
        for (int i = 0; i < 4; i++) begin
            dvd[i]      = (DIV_W'(side_in.mag[i]) << FRAC_BITS) + DIV_W'(t_in);
            ovf_next[i] = CMP_W'(dvd[i]) >= (CMP_W'(dsr) << Q_W);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld0_reg <= 1'b0;
        end else if (en) begin
            vld0_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem0_reg  <= dvd;
            ovf0_reg  <= ovf_next;
            d0_reg    <= dsr;
            t0_reg    <= t_in;
            side0_reg <= side_in;
        end
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        localparam int SH = Q_W - 1 - k;
        logic [3:0][DIV_W-1:0] rem_cur;
        logic [3:0][Q_W-1:0]   q_cur;
        logic [3:0]            ovf_cur;
        logic [T_W:0]          d_cur;
        logic [T_W-1:0]        t_cur;
        side_t                 side_cur;
        logic                  vld_cur;
        logic [CMP_W-1:0]      dsh;

        if (k == 0) begin : g_first
            assign rem_cur  = rem0_reg;
            assign q_cur    = '0;
            assign ovf_cur  = ovf0_reg;
            assign d_cur    = d0_reg;
            assign t_cur    = t0_reg;
            assign side_cur = side0_reg;
            assign vld_cur  = vld0_reg;
        end else begin : g_next
            assign rem_cur  = rem_reg[k-1];
            assign q_cur    = q_reg[k-1];
            assign ovf_cur  = ovf_reg[k-1];
            assign d_cur    = d_reg[k-1];
            assign t_cur    = t_reg[k-1];
            assign side_cur = side_reg[k-1];
            assign vld_cur  = vld_reg[k-1];
        end

        assign dsh = CMP_W'(d_cur) << SH;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ovf_reg[k]  <= ovf_cur;
                d_reg[k]    <= d_cur;
                t_reg[k]    <= t_cur;
                side_reg[k] <= side_cur;
                for (int i = 0; i < 4; i++) begin
                    if (CMP_W'(rem_cur[i]) >= dsh) begin
                        rem_reg[k][i] <= DIV_W'(CMP_W'(rem_cur[i]) - dsh);
                        q_reg[k][i]   <= q_cur[i] | (Q_W'(1) << SH);
                    end else begin
                        rem_reg[k][i] <= rem_cur[i];
                        q_reg[k][i]   <= q_cur[i];
                    end
                end
            end
        end
    end

    assign valid_out = vld_reg[Q_W-1];
    assign q_out     = q_reg[Q_W-1];
    assign ovf_out   = ovf_reg[Q_W-1];
    assign t_out     = t_reg[Q_W-1];
    assign side_out  = side_reg[Q_W-1];

endmodule

/* src/rotation_matrix_to_quaternion.sv */
// top level: rotation matrix in Q2.14 to unit quaternion, fully pipelined
// depends on rmq_pkg, rmq_front, rmq_sqrt, rmq_div
//
// Converts a 3x3 rotation matrix (nine signed Q2.14 elements) into a quaternion
// (x, y, z, w) in Q2.14 by Shepperd's method. A new request is taken every cycle
// while the output is not stalled, and each result passes in order through the
// branch choice register, the bit-per-stage square root and its rounding stage,
// the divider setup stage, the bit-per-stage dividers and the output register.
// Latency is set by the square root and divider pipelines. When m_ready is low
// while a result is waiting, the whole pipe holds in place, so nothing is
// dropped or repeated. A radicand that is not positive (the matrix is not a
// rotation) gives all four components at the positive limit with m_degenerate
// set.
module rotation_matrix_to_quaternion import rmq_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic signed [IN_W-1:0] s_r00,
    input  logic signed [IN_W-1:0] s_r01,
    input  logic signed [IN_W-1:0] s_r02,
    input  logic signed [IN_W-1:0] s_r10,
    input  logic signed [IN_W-1:0] s_r11,
    input  logic signed [IN_W-1:0] s_r12,
    input  logic signed [IN_W-1:0] s_r20,
    input  logic signed [IN_W-1:0] s_r21,
    input  logic signed [IN_W-1:0] s_r22,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic signed [IN_W-1:0] m_quat_x,
    output logic signed [IN_W-1:0] m_quat_y,
    output logic signed [IN_W-1:0] m_quat_z,
    output logic signed [IN_W-1:0] m_quat_w,
    output logic                   m_degenerate
);

    // global pipe enable: advance whenever the output slot is free or drained
    logic en;

    logic             f_valid;
    logic [RAD_W-1:0] f_rad;
    side_t            f_side;

    logic             s2_valid;
    logic [T_W-1:0]   s2_t;
    side_t            s2_side;

    logic                d_valid;
    logic [3:0][Q_W-1:0] d_q;
    logic [3:0]          d_ovf;
    logic [T_W-1:0]      d_t;
    side_t               d_side;

    logic signed [IN_W-1:0] comp_next [4];
    logic [T_W-1:0]         half_t;

    logic                   out_valid_reg;
    logic signed [IN_W-1:0] out_comp_reg [4];
    logic                   out_degen_reg;

    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    rmq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (s_valid),
        .r00       (s_r00), .r01 (s_r01), .r02 (s_r02),
        .r10       (s_r10), .r11 (s_r11), .r12 (s_r12),
        .r20       (s_r20), .r21 (s_r21), .r22 (s_r22),
        .valid_out (f_valid),
        .rad_out   (f_rad),
        .side_out  (f_side)
    );

    rmq_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (f_valid),
        .rad_in    (f_rad),
        .side_in   (f_side),
        .valid_out (s2_valid),
        .t_out     (s2_t),
        .side_out  (s2_side)
    );

    rmq_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (s2_valid),
        .t_in      (s2_t),
        .side_in   (s2_side),
        .valid_out (d_valid),
        .q_out     (d_q),
        .ovf_out   (d_ovf),
        .t_out     (d_t),
        .side_out  (d_side)
    );

    // final: all max if degen, else branch t/2 rounded up, others sign and clamp
    always_comb begin
        half_t = (d_t + T_W'(1)) >> 1;
        for (int i = 0; i < 4; i++) begin
            if (d_side.degen) begin
                comp_next[i] = SAT_MAX;
            end else if (comp_t'(i) == d_side.big) begin
                comp_next[i] = (half_t > T_W'(SAT_MAX)) ? SAT_MAX : IN_W'(half_t);
            end else if (d_ovf[i]) begin
                comp_next[i] = d_side.neg[i] ? SAT_MIN : SAT_MAX;
            end else if (d_side.neg[i]) begin
                comp_next[i] = -IN_W'(d_q[i]);
            end else begin
                comp_next[i] = IN_W'(d_q[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_comp_reg  <= comp_next;
            out_degen_reg <= d_side.degen;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_quat_x     = out_comp_reg[COMP_X];
    assign m_quat_y     = out_comp_reg[COMP_Y];
    assign m_quat_z     = out_comp_reg[COMP_Z];
    assign m_quat_w     = out_comp_reg[COMP_W];
    assign m_degenerate = out_degen_reg;

    // a degenerate result always carries all components at the positive limit
    a_degen_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> m_quat_x == SAT_MAX && m_quat_y == SAT_MAX &&
                                    m_quat_z == SAT_MAX && m_quat_w == SAT_MAX)
        else $error("degenerate result not saturated");

    // input side takes requests exactly when the output slot can move
    a_ready_link: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("s_ready out of step with output slot");

    // a stalled result stays valid, with quat_x and quat_w held, until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_quat_x) && $stable(m_quat_w))
        else $error("stalled result changed");

endmodule

/* dv/tb.sv */
// testbench for rotation_matrix_to_quaternion: directed table plus random matrices
// depends on rmq_pkg and the rotation_matrix_to_quaternion rtl
`timescale 1ns / 100ps

module tb;
    import rmq_pkg::*;

    typedef logic signed [IN_W-1:0] elem_t;

    // one quaternion result as it leaves the block
    typedef struct {
        elem_t qx;
        elem_t qy;
        elem_t qz;
        elem_t qw;
        logic  degen;
    } quat_t;

    // directed row: matrix, and an optional typed-in expectation
    typedef struct {
        elem_t m[9];
        logic  has_exp;
        quat_t exp_q;
    } dir_row_t;

    localparam int N_RANDOM = 1830;
    localparam int LATENCY  = 35;
    localparam longint ONE_L = longint'(1) << FRAC_BITS;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    elem_t s_r00, s_r01, s_r02, s_r10, s_r11, s_r12, s_r20, s_r21, s_r22;
    logic m_valid;
    logic m_ready;
    elem_t m_quat_x, m_quat_y, m_quat_z, m_quat_w;
    logic m_degenerate;

    quat_t pending_quats[$];
    int    n_errors;
    int    n_requests;
    int    n_results;
    int    n_degen;
    int    branch_hits[4];
    logic  quiet_tail;

    rotation_matrix_to_quaternion u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_r00        (s_r00),
        .s_r01        (s_r01),
        .s_r02        (s_r02),
        .s_r10        (s_r10),
        .s_r11        (s_r11),
        .s_r12        (s_r12),
        .s_r20        (s_r20),
        .s_r21        (s_r21),
        .s_r22        (s_r22),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_quat_x     (m_quat_x),
        .m_quat_y     (m_quat_y),
        .m_quat_z     (m_quat_z),
        .m_quat_w     (m_quat_w),
        .m_degenerate (m_degenerate)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // rounded integer square root, exact
    function automatic longint root_rounded(longint v);
        longint r;
        longint b;
        r = 0;
        b = longint'(1) << 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        // remainder above r means the true root is past the half point
        if (v > r) r = r + 1;
        return r;
    endfunction

    // n / (2t) in the fixed-point format, ties away from zero
    function automatic longint scaled_quot(longint n, longint t);
        longint mag;
        longint q;
        mag = (n < 0) ? -n : n;
        q = ((mag << FRAC_BITS) + t) / (2 * t);
        return (n < 0) ? -q : q;
    endfunction

    function automatic elem_t clamp16(longint v);
        if (v > 32767) return SAT_MAX;
        if (v < -32768) return SAT_MIN;
        return elem_t'(v);
    endfunction

    // shepperd conversion; also reports which branch was taken
    function automatic quat_t matrix_to_quat(elem_t m[9], output comp_t branch);
        longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
        longint tr;
        longint rad;
        longint t;
        longint num[4];
        longint v;
        quat_t q;
        a00 = m[0]; a01 = m[1]; a02 = m[2];
        a10 = m[3]; a11 = m[4]; a12 = m[5];
        a20 = m[6]; a21 = m[7]; a22 = m[8];
        tr = a00 + a11 + a22;
        if (tr > 0) begin
            rad = tr + ONE_L;
            branch = COMP_W;
            num[COMP_X] = a21 - a12; num[COMP_Y] = a02 - a20;
            num[COMP_Z] = a10 - a01; num[COMP_W] = 0;
        end else if (a00 > a11 && a00 > a22) begin
            rad = ONE_L + a00 - a11 - a22;
            branch = COMP_X;
            num[COMP_W] = a21 - a12; num[COMP_Y] = a01 + a10;
            num[COMP_Z] = a02 + a20; num[COMP_X] = 0;
        end else if (a11 > a22) begin
            rad = ONE_L + a11 - a00 - a22;
            branch = COMP_Y;
            num[COMP_W] = a02 - a20; num[COMP_X] = a01 + a10;
            num[COMP_Z] = a12 + a21; num[COMP_Y] = 0;
        end else begin
            rad = ONE_L + a22 - a00 - a11;
            branch = COMP_Z;
            num[COMP_W] = a10 - a01; num[COMP_X] = a02 + a20;
            num[COMP_Y] = a12 + a21; num[COMP_Z] = 0;
        end
        if (rad <= 0) begin
            // not a rotation: everything pinned at the positive limit
            q.qx = SAT_MAX; q.qy = SAT_MAX; q.qz = SAT_MAX; q.qw = SAT_MAX;
            q.degen = 1'b1;
            return q;
        end
        t = root_rounded(rad << FRAC_BITS);
        for (int i = 0; i < 4; i++) begin
            if (i == int'(branch)) v = (t + 1) >>> 1;
            else v = scaled_quot(num[i], t);
            case (i)
                0: q.qx = clamp16(v);
                1: q.qy = clamp16(v);
                2: q.qz = clamp16(v);
                default: q.qw = clamp16(v);
            endcase
        end
        q.degen = 1'b0;
        return q;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        n_errors++;
        $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    endtask

    // drive one request and hold it until accepted; random gaps before it
    task automatic send_request(elem_t m[9]);
        int gap;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_r00 <= m[0]; s_r01 <= m[1]; s_r02 <= m[2];
        s_r10 <= m[3]; s_r11 <= m[4]; s_r12 <= m[5];
        s_r20 <= m[6]; s_r21 <= m[7]; s_r22 <= m[8];
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    function automatic dir_row_t mk_row(elem_t m[9]);
        dir_row_t r;
        r.m = m;
        r.has_exp = 1'b0;
        return r;
    endfunction

    function automatic dir_row_t mk_row_exp(elem_t m[9], elem_t qx, elem_t qy, elem_t qz,
                                            elem_t qw, logic dg);
        dir_row_t r;
        r.m = m;
        r.has_exp = 1'b1;
        r.exp_q.qx = qx; r.exp_q.qy = qy; r.exp_q.qz = qz; r.exp_q.qw = qw;
        r.exp_q.degen = dg;
        return r;
    endfunction

    // random matrix: mostly entries of at most 1.0 with a chosen dominant branch,
    // some with diagonal ties, the rest raw noise over the full field range
    function automatic void random_matrix(output elem_t m[9]);
        int kind;
        int dom;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++) m[i] = elem_t'($urandom);
        if (kind < 7) begin
            dom = $urandom_range(0, 3);
            for (int i = 0; i < 9; i++) m[i] = elem_t'($urandom_range(0, 32768) - 16384);
            if (dom == 3) begin
                // non-negative x and y diagonal, aiming at the trace branch
                m[0] = elem_t'($urandom_range(0, 16384));
                m[4] = elem_t'($urandom_range(0, 16384));
                m[8] = elem_t'($urandom_range(0, 32768) - 16384);
            end else begin
                m[0] = elem_t'(-$urandom_range(0, 16384));
                m[4] = elem_t'(-$urandom_range(0, 16384));
                m[8] = elem_t'(-$urandom_range(0, 16384));
                m[dom * 4] = elem_t'($urandom_range(0, 16384));
            end
        end else if (kind == 7) begin
            // diagonal ties
            m[0] = elem_t'($urandom_range(0, 32768) - 16384);
            m[4] = ($urandom_range(0, 1) == 1) ? m[0] : elem_t'(-16384);
            m[8] = ($urandom_range(0, 1) == 1) ? m[0] : m[4];
        end
    endfunction

    // output side: random stall bursts
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                stall = $urandom_range(1, 7);
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // compare each result with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (pending_quats.size() == 0) begin
                n_errors++;
                $display("[%0t] result with no request waiting", $realtime);
            end else begin
                quat_t want;
                want = pending_quats.pop_front();
                if (m_quat_x !== want.qx) report_mismatch("quat_x", m_quat_x, want.qx);
                if (m_quat_y !== want.qy) report_mismatch("quat_y", m_quat_y, want.qy);
                if (m_quat_z !== want.qz) report_mismatch("quat_z", m_quat_z, want.qz);
                if (m_quat_w !== want.qw) report_mismatch("quat_w", m_quat_w, want.qw);
                if (m_degenerate !== want.degen)
                    report_mismatch("degenerate", m_degenerate, want.degen);
            end
        end
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        dir_row_t rows[$];
        elem_t m[9];
        quat_t q;
        comp_t br;
        int drain;

        n_errors = 0; n_requests = 0; n_results = 0; n_degen = 0;
        for (int i = 0; i < 4; i++) branch_hits[i] = 0;
        quiet_tail = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        {s_r00, s_r01, s_r02, s_r10, s_r11, s_r12, s_r20, s_r21, s_r22} = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // identity: trace branch, w = 1.0
        rows.push_back(mk_row_exp('{16384, 0, 0, 0, 16384, 0, 0, 0, 16384},
                                  0, 0, 0, 16384, 1'b0));
        // half-turns about each axis
        rows.push_back(mk_row_exp('{16384, 0, 0, 0, -16384, 0, 0, 0, -16384},
                                  16384, 0, 0, 0, 1'b0));
        rows.push_back(mk_row_exp('{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384},
                                  0, 16384, 0, 0, 1'b0));
        rows.push_back(mk_row_exp('{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384},
                                  0, 0, 16384, 0, 1'b0));
        // all-min diagonal: ties fall to the z branch with radicand 3/4 * 2^16
        rows.push_back(mk_row_exp('{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768},
                                  0, 0, 14189, 0, 1'b0));
        // only the last diagonal element negative: y branch with radicand 2.0
        rows.push_back(mk_row_exp('{0, 0, 0, 0, 0, 0, 0, 0, -16384},
                                  0, 11585, 0, 0, 1'b0));
        // all zero: trace not positive, ties fall to z branch
        rows.push_back(mk_row('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
        // all max and all min elements, off-diagonal saturation
        rows.push_back(mk_row('{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}));
        rows.push_back(mk_row('{-32768, -32768, -32768, -32768, -32768, -32768,
                                -32768, -32768, -32768}));
        rows.push_back(mk_row('{-32768, 32767, -32768, 32767, -32768, 32767,
                                -32768, 32767, -32768}));
        rows.push_back(mk_row('{1, -32768, 32767, 32767, 0, -32768, -32768, 32767, 0}));
        // smallest positive trace
        rows.push_back(mk_row('{1, 100, -200, 300, 0, -400, 500, -600, 0}));
        // ties on the diagonal
        rows.push_back(mk_row('{-8192, 3000, -3000, 2000, -8192, 1000, -1000, 500, -9000}));
        rows.push_back(mk_row('{-8192, 3000, -3000, 2000, -9000, 1000, -1000, 500, -8192}));
        rows.push_back(mk_row('{-9000, 3000, -3000, 2000, -8192, 1000, -1000, 500, -8192}));
        // non-rotation with positive radicand, large off-diagonals
        rows.push_back(mk_row('{-16384, 32767, -32768, -32768, -16384, 32767,
                                32767, -32768, -16383}));
        // 90 degree turn about z
        rows.push_back(mk_row('{0, -16384, 0, 16384, 0, 0, 0, 0, 16384}));
        // alternating bit patterns
        rows.push_back(mk_row('{21845, -21846, 21845, -21846, 21845, -21846,
                                21845, -21846, 21845}));

        foreach (rows[k]) begin
            q = matrix_to_quat(rows[k].m, br);
            if (rows[k].has_exp) q = rows[k].exp_q;
            if (q.degen) n_degen++; else branch_hits[br]++;
            pending_quats.push_back(q);
            n_requests++;
            send_request(rows[k].m);
        end

        for (int k = 0; k < N_RANDOM; k++) begin
            // last stretch runs at full rate on both sides
            if (k == N_RANDOM - 200) quiet_tail = 1'b1;
            random_matrix(m);
            q = matrix_to_quat(m, br);
            if (q.degen) n_degen++; else branch_hits[br]++;
            pending_quats.push_back(q);
            n_requests++;
            send_request(m);
        end
        s_valid <= 1'b0;

        drain = 0;
        while (pending_quats.size() != 0 && drain < 100000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (LATENCY + 10) @(posedge aclk);

        $display("%0d requests, %0d results; branches x/y/z/w %0d/%0d/%0d/%0d, %0d degenerate",
                 n_requests, n_results, branch_hits[0], branch_hits[1], branch_hits[2],
                 branch_hits[3], n_degen);
        if (n_errors == 0 && pending_quats.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d results outstanding", n_errors, pending_quats.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
